// File: rtl/htwd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htwd_pkg: shared types and constants of the tree-walk decoder
// node entry layout, beat structs and item kind codes
// ----------------------------------------------------------------------------
package htwd_pkg;

	localparam int MAX_NODES = 512;
	localparam int AW        = $clog2(MAX_NODES);
	localparam int NODE_W    = 9;
	localparam int SYM_W     = 8;
	localparam int MAX_BITS  = 8;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [NODE_W-1:0] node_index;
		logic [NODE_W-1:0] left_child;
		logic [NODE_W-1:0] right_child;
		logic              is_leaf;
		logic [SYM_W-1:0]  leaf_symbol;
		logic [7:0]        code_byte;
		logic [3:0]        bit_count;
	} item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last_of_run;
	} result_t;

	// one tree table entry
	typedef struct packed {
		logic [NODE_W-1:0] left;
		logic [NODE_W-1:0] right;
		logic              is_leaf;
		logic [SYM_W-1:0]  leaf_symbol;
	} node_t;

	// request from the walker to the result buffer
	typedef struct packed {
		logic             push;
		logic             flush;
		logic [SYM_W-1:0] sym;
	} sym_op_t;

endpackage
`default_nettype wire

// File: rtl/huffman_tree_walk_decoder_core.sv
`default_nettype none
// a data beat walks its valid bits one tree level at a time, then flushes the result buffer
// throughput: a load beat per cycle; a data beat holds off new beats until its walk and flush are done
// the walk advances one tree level per cycle, unless a result stall holds it, through the single node table read port
// result stalls hold the walk when a new leaf meets a full result buffer
// reset: arst_n clears the sequencer, walk position and result buffer at once
// the node table has no reset and is undefined until loaded
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_core: bit-serial huffman tree walk decoder
// load beats write tree nodes, data beats walk up to eight code bits msb first
// and emit one symbol per leaf reached, the last one of a beat marked
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_core import htwd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	output logic       result_valid,
	input  wire logic  result_stall,
	output result_t    result
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_WALK  = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

	state_t state_q, state_d;

	// walk position kept across data beats
	logic [AW-1:0] cur_node_q, cur_node_d;
	// read address of the node table, held while the walk waits
	logic [AW-1:0] rd_addr_q, rd_addr;
	logic [3:0]    cnt_q, cnt_d;
	logic [7:0]    bits_q, bits_d;
	// ram data is a node just moved to and needs its leaf check
	logic          chk_q, chk_d;
	// walk sits at the root, take the root copy instead of ram data
	logic          root_sel_q, root_sel_d;

	node_t         ram_q;
	node_t         root_q;
	node_t         cur_ent;
	node_t         wr_ent;
	logic          we;
	logic          accept;
	logic          leaf_hit;
	logic          hold;
	logic [NODE_W-1:0] child;
	logic          child_oob;
	logic [3:0]    n_bits;
	sym_op_t       op;
	logic          buf_ready;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;

	// node entry from a load beat
	always_comb begin
		wr_ent.left        = item.left_child;
		wr_ent.right       = item.right_child;
		wr_ent.is_leaf     = item.is_leaf;
		wr_ent.leaf_symbol = item.leaf_symbol;
	end

	// counts above eight saturate
	assign n_bits = (item.bit_count > 4'(MAX_BITS)) ? 4'(MAX_BITS) : item.bit_count;

	// a leaf reached sends the walk back to the root in the same cycle
	assign leaf_hit  = (state_q == S_WALK) && chk_q && ram_q.is_leaf;
	assign cur_ent   = (leaf_hit || root_sel_q) ? root_q : ram_q;
	assign child     = bits_q[7] ? cur_ent.right : cur_ent.left;
	assign child_oob = (32'(child) >= MAX_NODES);

	// sequencer and bit step
	always_comb begin
		state_d    = state_q;
		cur_node_d = cur_node_q;
		rd_addr    = rd_addr_q;
		cnt_d      = cnt_q;
		bits_d     = bits_q;
		chk_d      = chk_q;
		root_sel_d = root_sel_q;
		we         = 1'b0;
		hold       = 1'b0;
		op         = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (item.kind == KIND_LOAD) begin
						// loads beyond the table are dropped
						we = (32'(item.node_index) < MAX_NODES);
					end else if (n_bits != 4'd0) begin
						cnt_d      = n_bits;
						bits_d     = item.code_byte;
						rd_addr    = cur_node_q;
						chk_d      = 1'b0;
						root_sel_d = 1'b0;
						state_d    = S_WALK;
					end
				end
			end
			S_WALK: begin
				op.push = leaf_hit;
				op.sym  = ram_q.leaf_symbol;
				hold    = leaf_hit && !buf_ready;
				if (!hold) begin
					if (leaf_hit) begin
						cur_node_d = '0;
					end
					if (cnt_q == 4'd0) begin
						// last leaf check done
						chk_d   = 1'b0;
						state_d = S_FLUSH;
					end else begin
						cnt_d  = cnt_q - 4'd1;
						bits_d = {bits_q[6:0], 1'b0};
						if (child_oob) begin
							// child outside the table: back to root, no symbol
							cur_node_d = '0;
							chk_d      = 1'b0;
							root_sel_d = 1'b1;
						end else begin
							cur_node_d = AW'(child);
							rd_addr    = AW'(child);
							chk_d      = 1'b1;
							root_sel_d = 1'b0;
						end
					end
				end
			end
			S_FLUSH: begin
				op.flush = 1'b1;
				if (buf_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cur_node_q <= '0;
			rd_addr_q  <= '0;
			cnt_q      <= '0;
			chk_q      <= 1'b0;
			root_sel_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cur_node_q <= cur_node_d;
			rd_addr_q  <= rd_addr;
			cnt_q      <= cnt_d;
			chk_q      <= chk_d;
			root_sel_q <= root_sel_d;
		end
	end

	// code bits and the root copy carry no reset
	always_ff @(posedge clk) begin
		bits_q <= bits_d;
		if (we && (AW'(item.node_index) == '0)) begin
			root_q <= wr_ent;
		end
	end

	htwd_tree_ram u_tree_ram (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(item.node_index)),
		.wdata (wr_ent),
		.raddr (rd_addr),
		.rdata (ram_q)
	);

	htwd_out_buf u_out_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.ready        (buf_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (cnt_q <= 4'(MAX_BITS)))
		else $error("bit counter out of range");

	a_data_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.kind == KIND_DATA && item.bit_count != 4'd0) |=>
			(state_q == S_WALK && cnt_q != 4'd0))
		else $error("data beat did not start a walk");

	a_hold_freezes_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && hold) |=>
			(state_q == S_WALK && $stable(cnt_q) && $stable(bits_q) && $stable(rd_addr_q)))
		else $error("walk moved while waiting on result buffer");

endmodule
`default_nettype wire

// File: rtl/htwd_tree_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htwd_tree_ram: code tree node table
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module htwd_tree_ram import htwd_pkg::*; (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire node_t         wdata,
	input  wire logic [AW-1:0] raddr,
	output node_t              rdata
);

	node_t mem_q [MAX_NODES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/htwd_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// htwd_out_buf: pending symbol and result register
// holds back one symbol so the final one of a run can carry its last mark
// ----------------------------------------------------------------------------
module htwd_out_buf import htwd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire sym_op_t op,
	output logic         ready,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	logic             out_v_q;
	result_t          out_q;
	logic             pend_v_q;
	logic [SYM_W-1:0] pend_sym_q;
	logic             slot_free;
	logic             load_out;

	assign slot_free = !out_v_q || !result_stall;
	assign ready     = !pend_v_q || slot_free;
	assign load_out  = pend_v_q && slot_free && (op.push || op.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (!result_stall) begin
				out_v_q <= 1'b0;
			end
			if (op.push && ready) begin
				pend_v_q <= 1'b1;
			end else if (op.flush && ready) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.symbol      <= pend_sym_q;
			out_q.last_of_run <= op.flush;
		end
		if (op.push && ready) begin
			pend_sym_q <= op.sym;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

	a_flush_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		(op.flush && pend_v_q && slot_free) |=> (out_v_q && out_q.last_of_run && !pend_v_q))
		else $error("flush did not send a last beat");

	a_push_moves_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(op.push && pend_v_q && slot_free) |=>
			(out_v_q && !out_q.last_of_run && out_q.symbol == $past(pend_sym_q)))
		else $error("pending symbol not moved to result register");

	a_push_fills_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(op.push && ready) |=> (pend_v_q && pend_sym_q == $past(op.sym)))
		else $error("pushed symbol not held as pending");

endmodule
`default_nettype wire

// File: sim/huffman_tree_walk_decoder_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_core_tb: self-checking bench for the tree walk decoder
// loads code trees into the node table, sends code bytes, and checks every
// decoded symbol and its end-of-beat mark against a bit-serial walk model
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_core_tb;
	import htwd_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 11;
	localparam int TARGET_BEATS   = 250;
	localparam int TAIL_BEATS     = 40;    // no idling on either side once this few are left
	localparam int MAX_BURST      = 17;
	localparam int DRAIN_CYCLES   = 20;    // room for a full byte's walk plus a flush
	localparam int WATCHDOG_LIMIT = 2000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// beats waiting to be sent, and symbols the decoder still owes us
	item_t   pending_beats[$];
	result_t expected_symbols[$];
	result_t want_symbol;

	// shadow of the node table and walk position, updated on accepted beats
	node_t                tree_model[MAX_NODES];
	logic [NODE_W-1:0]    walk_node = '0;

	// generator bookkeeping: which nodes hold something, so no walk ever
	// touches an entry that was never loaded
	bit                   node_written[MAX_NODES];
	int                   written_nodes[$];

	int n_load = 0;
	int n_data = 0;
	int n_results = 0;
	int n_errors = 0;
	int gap_left = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	huffman_tree_walk_decoder_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------------
	// walk model: one tree level per code bit, msb first
	// ------------------------------------------------------------------------
	task automatic decode_beat(input item_t b);
		logic [7:0]        bits;
		logic [NODE_W-1:0] nxt;
		int                nbits;
		int                first;
		result_t           sym;
		if (b.kind == KIND_LOAD) begin
			// loads just rewrite one node, the walk position stays put
			if (b.node_index < MAX_NODES) begin
				tree_model[b.node_index].left        = b.left_child;
				tree_model[b.node_index].right       = b.right_child;
				tree_model[b.node_index].is_leaf     = b.is_leaf;
				tree_model[b.node_index].leaf_symbol = b.leaf_symbol;
			end
		end else begin
			// counts above 8 saturate
			nbits = (b.bit_count > 4'(MAX_BITS)) ? MAX_BITS : int'(b.bit_count);
			bits  = b.code_byte;
			first = expected_symbols.size();
			for (int i = 0; i < nbits; i++) begin
				// a node rewritten into a leaf is still left through its children
				nxt  = bits[7] ? tree_model[walk_node].right : tree_model[walk_node].left;
				bits = bits << 1;
				if (nxt >= MAX_NODES) begin
					// child beyond the table falls back to the root, no symbol
					walk_node = '0;
				end else if (tree_model[nxt].is_leaf) begin
					sym.symbol      = tree_model[nxt].leaf_symbol;
					sym.last_of_run = 1'b0;
					expected_symbols.push_back(sym);
					walk_node = '0;
				end else begin
					walk_node = nxt;
				end
			end
			// mark the final symbol of this beat
			if (expected_symbols.size() > first) begin
				sym = expected_symbols.pop_back();
				sym.last_of_run = 1'b1;
				expected_symbols.push_back(sym);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// stimulus builders: ignored fields of each beat carry random junk
	// ------------------------------------------------------------------------
	function automatic item_t random_item();
		item_t it;
		it.kind        = KIND_DATA;
		it.node_index  = NODE_W'($urandom_range(0, 511));
		it.left_child  = NODE_W'($urandom_range(0, 511));
		it.right_child = NODE_W'($urandom_range(0, 511));
		it.is_leaf     = 1'($urandom_range(0, 1));
		it.leaf_symbol = SYM_W'($urandom_range(0, 255));
		it.code_byte   = 8'($urandom_range(0, 255));
		it.bit_count   = 4'($urandom_range(0, 15));
		return it;
	endfunction

	task automatic push_load(input int idx, input int l, input int r, input bit leaf,
			input int sym);
		item_t it;
		it             = random_item();
		it.kind        = KIND_LOAD;
		it.node_index  = NODE_W'(idx);
		it.left_child  = NODE_W'(l);
		it.right_child = NODE_W'(r);
		it.is_leaf     = leaf;
		it.leaf_symbol = SYM_W'(sym);
		pending_beats.push_back(it);
		if (!node_written[idx]) begin
			node_written[idx] = 1'b1;
			written_nodes.push_back(idx);
		end
	endtask

	task automatic push_data(input int code, input int cnt);
		item_t it;
		it           = random_item();
		it.kind      = KIND_DATA;
		it.code_byte = 8'(code);
		it.bit_count = 4'(cnt);
		pending_beats.push_back(it);
	endtask

	// random full binary tree rooted at node 0, other nodes scattered over the
	// table; leaf children point back into the tree so a rewritten leaf stays safe
	task automatic load_random_tree(input int max_internal);
		bit in_tree[MAX_NODES];
		int t_idx[$];
		int t_l[$];
		int t_r[$];
		bit t_leaf[$];
		int slot_node[$];
		bit slot_right[$];
		int order[$];
		int internal;
		int k;
		int sp;
		bit sr;
		int ni;
		bit grow;
		t_idx.push_back(0);
		t_l.push_back(0);
		t_r.push_back(0);
		t_leaf.push_back(1'b0);
		in_tree[0] = 1'b1;
		slot_node  = '{0, 0};
		slot_right = '{1'b0, 1'b1};
		internal   = 1;
		while (slot_node.size() > 0) begin
			k  = $urandom_range(0, slot_node.size() - 1);
			sp = slot_node[k];
			sr = slot_right[k];
			slot_node.delete(k);
			slot_right.delete(k);
			do ni = $urandom_range(1, MAX_NODES - 1); while (in_tree[ni]);
			in_tree[ni] = 1'b1;
			grow = (internal < max_internal) && ($urandom_range(0, 2) != 0);
			if (sr)
				t_r[sp] = ni;
			else
				t_l[sp] = ni;
			t_idx.push_back(ni);
			t_l.push_back(0);
			t_r.push_back(0);
			t_leaf.push_back(!grow);
			if (grow) begin
				internal++;
				slot_node.push_back(t_idx.size() - 1);
				slot_right.push_back(1'b0);
				slot_node.push_back(t_idx.size() - 1);
				slot_right.push_back(1'b1);
			end
		end
		foreach (t_idx[i]) begin
			order.push_back(i);
			if (t_leaf[i]) begin
				t_l[i] = t_idx[$urandom_range(0, t_idx.size() - 1)];
				t_r[i] = t_idx[$urandom_range(0, t_idx.size() - 1)];
			end
		end
		// nodes go out in shuffled order
		while (order.size() > 0) begin
			k = $urandom_range(0, order.size() - 1);
			push_load(t_idx[order[k]], t_l[order[k]], t_r[order[k]], t_leaf[order[k]],
				$urandom_range(0, 255));
			order.delete(k);
		end
	endtask

	// ------------------------------------------------------------------------
	// driver: one beat per handshake, random idle bursts until the tail
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
			gap_left   <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				decode_beat(item);
				if (item.kind == KIND_LOAD)
					n_load++;
				else
					n_data++;
			end
			// a stalled beat is held as is
			if (!item_valid || !item_stall) begin
				if (gap_left > 0) begin
					item_valid <= 1'b0;
					gap_left   <= gap_left - 1;
				end else if (pending_beats.size() == 0) begin
					item_valid <= 1'b0;
				end else if (pending_beats.size() > TAIL_BEATS && $urandom_range(0, 5) == 0) begin
					item_valid <= 1'b0;
					gap_left   <= $urandom_range(1, MAX_BURST) - 1;
				end else begin
					item_valid <= 1'b1;
					item       <= pending_beats.pop_front();
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: check each accepted symbol against the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left   <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				n_results++;
				if (expected_symbols.size() == 0) begin
					$error("symbol 0x%02h arrived with nothing expected", result.symbol);
					n_errors++;
				end else begin
					want_symbol = expected_symbols.pop_front();
					if (result.symbol !== want_symbol.symbol) begin
						$error("symbol: expected 0x%02h, got 0x%02h",
							want_symbol.symbol, result.symbol);
						n_errors++;
					end
					if (result.last_of_run !== want_symbol.last_of_run) begin
						$error("last_of_run: expected %0b, got %0b",
							want_symbol.last_of_run, result.last_of_run);
						n_errors++;
					end
				end
			end
			// backpressure bursts, none in the tail
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left   <= stall_left - 1;
			end else if (pending_beats.size() > TAIL_BEATS && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				stall_left   <= $urandom_range(1, MAX_BURST) - 1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// watchdog: too long without any beat on either side means a hang
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d cycles with no beat", quiet_cycles);
			$display("[huffman_tree_walk_decoder_core] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int k;
		int idx;
		int l;
		int r;
		int cnt;

		// directed tree: 0 -> leaf 0x00, 10 -> leaf 0xff, 11 -> leaf 0xa5
		// indices 0 and 511 and symbols 0x00/0xff hit both ends of every field
		push_load(0, 1, 511, 1'b0, 8'h5a);
		push_load(1, 0, 0, 1'b1, 8'h00);
		push_load(511, 256, 2, 1'b0, 8'hff);
		push_load(256, 511, 511, 1'b1, 8'hff);
		push_load(2, 0, 0, 1'b1, 8'ha5);
		push_data(8'h00, 8);     // eight leaves in one beat
		push_data(8'hff, 0);     // zero bits, nothing out
		push_data(8'hff, 8);
		push_data(8'haa, 8);
		push_data(8'h55, 15);    // count saturates, walk ends mid-code at 511
		push_data(8'h00, 1);     // walk position carried across beats
		push_data(8'h80, 1);     // park at 511 again
		// turn the parked node into a leaf, then walk out of it
		push_load(511, 1, 2, 1'b1, 8'h3c);
		push_data(8'h00, 2);
		push_data(8'h80, 1);
		push_data(8'hc0, 9);

		// random phases: fresh tree, then code bytes with a few stray loads
		while (pending_beats.size() < TARGET_BEATS) begin
			load_random_tree(($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10));
			repeat ($urandom_range(10, 30)) begin
				if ($urandom_range(0, 9) == 0) begin
					// stray load, children only among loaded nodes (or itself)
					idx = $urandom_range(0, 1) ?
						written_nodes[$urandom_range(0, written_nodes.size() - 1)] :
						$urandom_range(0, MAX_NODES - 1);
					k = $urandom_range(0, written_nodes.size());
					l = (k == written_nodes.size()) ? idx : written_nodes[k];
					k = $urandom_range(0, written_nodes.size());
					r = (k == written_nodes.size()) ? idx : written_nodes[k];
					push_load(idx, l, r, 1'($urandom_range(0, 1)), $urandom_range(0, 255));
				end else begin
					case ($urandom_range(0, 9))
						0: cnt = 0;
						1: cnt = $urandom_range(9, 15);
						2, 3, 4: cnt = 8;
						default: cnt = $urandom_range(1, 7);
					endcase
					push_data($urandom_range(0, 255), cnt);
				end
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// poll on the falling edge, away from the driving edge
		while (pending_beats.size() != 0 || item_valid) @(negedge clk);
		while (expected_symbols.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d node loads and %0d code beats, %0d symbols checked",
			n_load, n_data, n_results);
		if (n_errors == 0) begin
			$display("[huffman_tree_walk_decoder_core] OK");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("[huffman_tree_walk_decoder_core] ERROR");
		end
		$finish;
	end

endmodule
